@@ rtl/rgbsob_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbsob_pkg: shared types and constants of the RGB Sobel magnitude block
// Holds the payload words, the line buffer word, the register indexes,
// the controller states and the fixed arithmetic constants.
// ----------------------------------------------------------------------------
package rgbsob_pkg;

	// Input word: one RGB pixel.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_in_t;

	// Output word: one edge magnitude with its centre position.
	typedef struct packed {
		logic [7:0]  magnitude;
		logic [11:0] centre_row;
		logic [9:0]  centre_col;
		logic        has_centre;
		logic        frame_end;
	} pix_out_t;

	// One line buffer entry: gray of the row two above and of the row above.
	typedef struct packed {
		logic [7:0] older;
		logic [7:0] newer;
	} lb_word_t;

	// Configuration port.
	localparam int CFG_DATA_W = 13;
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
	localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd1;

	localparam int IMG_W_BITS = 11;
	localparam int IMG_H_BITS = 13;
	localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = 13'd480;
	localparam int MIN_DIM    = 3;
	localparam int HEIGHT_MAX = 4096;

	// Gray conversion weights, scaled by 1024.
	localparam int GRAY_KR    = 307;
	localparam int GRAY_KG    = 604;
	localparam int GRAY_KB    = 113;
	localparam int GRAY_SHIFT = 10;

	// Clamp for the squared gradient; its square root is 255.
	localparam logic [15:0] MAG_CLAMP = 16'd65025;
	localparam int ROOT_W = 8;

	// Controller states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SQUARE,
		ST_START,
		ST_ROOT
	} ctl_state_t;

endpackage

@@ rtl/rgb_gray_sobel_magnitude_top.sv @@
// Each accepted word passes the memory read, squares and square root on to the
// output register. The next word is taken only once that one is loaded there;
// the eight-step square root and the serial line buffer read-modify-write hold
// one word at a time. Reset: control state clears at once, then a clearing pass
// writes zeros through all MAX_WIDTH line buffer entries with in_stall high.
// ----------------------------------------------------------------------------
// rgb_gray_sobel_magnitude_top: streaming 3x3 Sobel edge magnitude
// Converts RGB pixels to gray, keeps two gray rows in a memory and the two left
// columns of a 3x3 window in registers, and emits the clamped gradient magnitude
// for the pixel one row up and one column left of each input.
// ----------------------------------------------------------------------------
module rgb_gray_sobel_magnitude_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Pixel input channel.
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  rgbsob_pkg::pix_in_t                  in_word,
	// Magnitude output channel.
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output rgbsob_pkg::pix_out_t                 out_word,
	// Configuration write channel.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  rgbsob_pkg::cfg_idx_t                 cfg_index,
	input  logic [rgbsob_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rgbsob_pkg::*;

	// Column counters and line buffer addresses cover MAX_WIDTH entries. The
	// width compare is done wide enough for both the register and MAX_WIDTH.
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = ($clog2(MAX_WIDTH + 1) > IMG_W_BITS) ?
		$clog2(MAX_WIDTH + 1) : IMG_W_BITS;
	localparam logic [WW-1:0] W_MAX    = WW'(MAX_WIDTH);
	localparam logic [CW-1:0] COL_LAST = CW'(MAX_WIDTH - 1);

	// ------------------------------------------------------------------
	// Configuration registers. The port never pushes back; the user must write
	// only while the block is idle, the block itself does not enforce it.
	// ------------------------------------------------------------------
	logic [IMG_W_BITS-1:0] width_q;
	logic [IMG_H_BITS-1:0] height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[IMG_W_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[IMG_H_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Register values in use are clamped to the supported frame sizes.
	logic [WW-1:0]         w_ext;
	logic [WW-1:0]         w_eff;
	logic [IMG_H_BITS-1:0] h_eff;

	always_comb begin
		w_ext = WW'(width_q);
		if (w_ext < WW'(MIN_DIM)) begin
			w_eff = WW'(MIN_DIM);
		end else if (w_ext > W_MAX) begin
			w_eff = W_MAX;
		end else begin
			w_eff = w_ext;
		end
		if (height_q < IMG_H_BITS'(MIN_DIM)) begin
			h_eff = IMG_H_BITS'(MIN_DIM);
		end else if (height_q > IMG_H_BITS'(HEIGHT_MAX)) begin
			h_eff = IMG_H_BITS'(HEIGHT_MAX);
		end else begin
			h_eff = height_q;
		end
	end

	// ------------------------------------------------------------------
	// Controller state and the signals it drives.
	// ------------------------------------------------------------------
	ctl_state_t state_q, state_d;
	logic [CW-1:0] clr_q;
	logic          accept;
	logic          lb_rd_en;
	logic          lb_wr_en;
	logic [CW-1:0] lb_wr_addr;
	lb_word_t      lb_wr_data;
	lb_word_t      lb_rd_data;
	logic          sq_start;
	logic          sq_busy;
	logic [ROOT_W-1:0] sq_root;
	logic          out_free;
	logic          out_load;

	// ------------------------------------------------------------------
	// Position counters. They advance when a word is accepted, using the
	// frame size in effect at that moment; a column counter already past a new,
	// smaller width wraps after this pixel, a row counter at the end of its row.
	// ------------------------------------------------------------------
	logic [CW-1:0]         col_cnt_q;
	logic [11:0]           row_cnt_q;
	logic [WW-1:0]         col_inc;
	logic [IMG_H_BITS-1:0] row_inc;
	logic                  row_wrap;
	logic                  frame_wrap;

	always_comb begin
		col_inc    = WW'(col_cnt_q) + WW'(1);
		row_inc    = IMG_H_BITS'(row_cnt_q) + IMG_H_BITS'(1);
		row_wrap   = col_inc >= w_eff;
		frame_wrap = row_wrap && (row_inc >= h_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (accept) begin
			if (row_wrap) begin
				col_cnt_q <= '0;
				row_cnt_q <= frame_wrap ? 12'd0 : row_inc[11:0];
			end else begin
				col_cnt_q <= col_inc[CW-1:0];
			end
		end
	end

	// Gray conversion of the incoming pixel, weights scaled by 1024.
	logic [17:0] gray_sum;
	assign gray_sum = 18'(in_word.red)   * 18'(GRAY_KR)
	                + 18'(in_word.green) * 18'(GRAY_KG)
	                + 18'(in_word.blue)  * 18'(GRAY_KB);

	// Stage 1: the accepted word and its position, held for the whole item.
	logic [7:0]    gray_s1;
	logic [CW-1:0] col_s1;
	logic [11:0]   row_s1;
	logic          fend_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			gray_s1 <= gray_sum[GRAY_SHIFT +: 8];
			col_s1  <= col_cnt_q;
			row_s1  <= row_cnt_q;
			fend_s1 <= frame_wrap;
		end
	end

	logic has_centre;
	logic calc;
	assign has_centre = (row_s1 != 12'd0) && (col_s1 != CW'(0));
	assign calc       = (row_s1 >= 12'd2) && (col_s1 >= CW'(2));

	// ------------------------------------------------------------------
	// Line buffer memory. Each column entry holds the gray of the two rows
	// above. The word is read on accept and written back in the next cycle
	// with the rows moved up. Successive pixels always address different
	// columns and only one item is in flight, so no forwarding is needed.
	// ------------------------------------------------------------------
	rgbsob_linebuf #(
		.DEPTH (MAX_WIDTH)
	) u_linebuf (
		.clk     (clk),
		.rd_en   (lb_rd_en),
		.rd_addr (col_cnt_q),
		.rd_data (lb_rd_data),
		.wr_en   (lb_wr_en),
		.wr_addr (lb_wr_addr),
		.wr_data (lb_wr_data)
	);

	// ------------------------------------------------------------------
	// Window and gradients. The window holds the two previous columns of
	// the current three rows; the right column comes from the memory read
	// and the new gray value.
	// ------------------------------------------------------------------
	logic [7:0] win_q [6];

	logic signed [11:0] tl, ml, bl, tc, bc, tr, mr, br;
	logic signed [11:0] gx, gy;
	logic [9:0]         ax, ay;

	always_comb begin
		tl = $signed({4'b0, win_q[0]});
		ml = $signed({4'b0, win_q[1]});
		bl = $signed({4'b0, win_q[2]});
		tc = $signed({4'b0, win_q[3]});
		bc = $signed({4'b0, win_q[5]});
		tr = $signed({4'b0, lb_rd_data.older});
		mr = $signed({4'b0, lb_rd_data.newer});
		br = $signed({4'b0, gray_s1});
		gx = (tl - tr) + ((ml - mr) <<< 1) + (bl - br);
		gy = (tl - bl) + ((tc - bc) <<< 1) + (tr - br);
		ax = 10'(gx[11] ? -gx : gx);
		ay = 10'(gy[11] ? -gy : gy);
	end

	logic [9:0] ax_s2, ay_s2;

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			ax_s2    <= ax;
			ay_s2    <= ay;
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= lb_rd_data.older;
			win_q[4] <= lb_rd_data.newer;
			win_q[5] <= gray_s1;
		end
	end

	// Stage 3: squared gradients.
	logic [19:0] sqx_s3, sqy_s3;

	always_ff @(posedge clk) begin
		if (state_q == ST_SQUARE) begin
			sqx_s3 <= 20'(ax_s2) * 20'(ax_s2);
			sqy_s3 <= 20'(ay_s2) * 20'(ay_s2);
		end
	end

	// Sum, clamp, and hand to the root unit. Centres without a full window
	// give a zero magnitude.
	logic [20:0] sq_sum;
	logic [15:0] sq_value;

	always_comb begin
		sq_sum = 21'(sqx_s3) + 21'(sqy_s3);
		if (!calc) begin
			sq_value = '0;
		end else if (sq_sum > 21'(MAG_CLAMP)) begin
			sq_value = MAG_CLAMP;
		end else begin
			sq_value = sq_sum[15:0];
		end
	end

	rgbsob_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (sq_value),
		.busy   (sq_busy),
		.root   (sq_root)
	);

	// ------------------------------------------------------------------
	// Output register. It decouples the consumer, so a waiting result
	// does not keep the next pixel from being accepted.
	// ------------------------------------------------------------------
	logic     out_valid_q;
	pix_out_t out_word_q;
	logic [WW-1:0] col_m1;

	assign out_free = !out_valid_q || !out_stall;
	assign col_m1   = WW'(col_s1) - WW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q.magnitude  <= has_centre ? sq_root : 8'd0;
			out_word_q.centre_row <= has_centre ? (row_s1 - 12'd1) : 12'd0;
			out_word_q.centre_col <= has_centre ? col_m1[9:0] : 10'd0;
			out_word_q.has_centre <= has_centre;
			out_word_q.frame_end  <= fend_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// ------------------------------------------------------------------
	// Controller. After reset it sweeps the memory to zero, then handles
	// one pixel at a time: read, gradients and write-back, squares, sum,
	// square root, and finally the load of the output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CW'(1);
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		lb_rd_en   = 1'b0;
		lb_wr_en   = 1'b0;
		lb_wr_addr = col_s1;
		lb_wr_data = '{older: lb_rd_data.newer, newer: gray_s1};
		sq_start   = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				lb_wr_en   = 1'b1;
				lb_wr_addr = clr_q;
				lb_wr_data = '0;
				if (clr_q == COL_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				lb_rd_en = in_valid;
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				lb_wr_en = 1'b1;
				state_d  = ST_SQUARE;
			end
			ST_SQUARE: begin
				state_d = ST_START;
			end
			ST_START: begin
				sq_start = 1'b1;
				state_d  = ST_ROOT;
			end
			ST_ROOT: begin
				if (!sq_busy && out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && !in_stall;

	// An accepted pixel always moves on to the memory read cycle.
	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_READ))
		else $error("accepted word did not enter the read cycle");

	// A new output word only appears after the root unit has finished.
	a_out_from_root: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_ROOT && !sq_busy))
		else $error("output loaded outside the root state");

	// Border results carry zero magnitude and position.
	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_word_q.has_centre) |->
		(out_word_q.magnitude == 8'd0 && out_word_q.centre_row == 12'd0 &&
		 out_word_q.centre_col == 10'd0))
		else $error("border result with nonzero fields");

	// The last pixel of a frame leaves both counters at the frame start.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && fend_s1) |-> (row_cnt_q == 12'd0 && col_cnt_q == CW'(0)))
		else $error("counters not wrapped at frame end");

endmodule

@@ rtl/rgbsob_linebuf.sv @@
// ----------------------------------------------------------------------------
// rgbsob_linebuf: gray line buffer memory
// One synchronous memory holding both buffered rows per column, with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module rgbsob_linebuf #(
	parameter int DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [$clog2(DEPTH)-1:0]    rd_addr,
	output rgbsob_pkg::lb_word_t        rd_data,
	input  logic                        wr_en,
	input  logic [$clog2(DEPTH)-1:0]    wr_addr,
	input  rgbsob_pkg::lb_word_t        wr_data
);
	import rgbsob_pkg::*;

	lb_word_t mem [DEPTH];
	lb_word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/rgbsob_isqrt.sv @@
// ----------------------------------------------------------------------------
// rgbsob_isqrt: iterative integer square root
// Digit-by-digit floor square root of a 16-bit value, one result bit per
// cycle while busy, until all ROOT_W result bits are formed.
// ----------------------------------------------------------------------------
module rgbsob_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [15:0]                   value,
	output logic                          busy,
	output logic [rgbsob_pkg::ROOT_W-1:0] root
);
	import rgbsob_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      val_q;
	logic [ROOT_W:0]  rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [ROOT_W+2:0] rem_sh;
	logic [ROOT_W+1:0] trial;
	logic              take;

	always_comb begin
		rem_sh = {rem_q, val_q[15:14]};
		trial  = {root_q, 2'b01};
		take   = rem_sh >= (ROOT_W+3)'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[13:0], 2'b00};
			if (take) begin
				rem_q  <= (ROOT_W+1)'(rem_sh - (ROOT_W+3)'(trial));
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= (ROOT_W+1)'(rem_sh);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

	// A new value is only handed over once the previous root is complete.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("square root restarted while busy");

	// The finished remainder never exceeds twice the root.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (rem_q <= {root_q, 1'b0}))
		else $error("square root remainder out of bound");

	// The unit stays busy until its last step.
	a_full_run: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q != CNT_LAST) |=> busy_q)
		else $error("square root stopped early");

endmodule
